[hdl/ings_pkg.sv]
// ----------------------------------------------------------------------------
// Gaussian sample generator package
// Shared widths, rational-approximation coefficients, register indexes and
// the result type used by the pipeline modules.
// ----------------------------------------------------------------------------
package ings_pkg;

    // Uniform code width and the Q16.16 configuration/result widths.
    localparam int UB    = 32;
    localparam int MEAN_W = 32;
    localparam int SD_W  = 31;
    localparam int OUT_W = 32;

    // Logarithm datapath: Q30 mantissa and 30 fraction bits.
    localparam int MQ       = 30;
    localparam int M_W      = MQ + 1;
    localparam int SQ_STEPS = 30;
    localparam int E_W      = 5;
    localparam int K_W      = 31;
    localparam logic [K_W-1:0] TWO_LN2 = 31'd1488522236;

    // w = -2 ln v in Q30, t = sqrt(w) in Q26.
    localparam int W_W = 36;
    localparam int T_W = 29;
    localparam int X_W = 2 * T_W;
    localparam int SQRT_REM_W = T_W + 1;

    // Polynomials and quotient, Q26.
    localparam int FX    = 26;
    localparam int ACC_W = 34;
    localparam int R_W   = 30;
    localparam int Z_W   = 31;

    localparam logic [ACC_W-1:0] COEF_P [5] = '{
        34'd21624652, 34'd67108864, 34'd22967478, 34'd1370572, 34'd3044
    };
    localparam logic [ACC_W-1:0] COEF_Q [5] = '{
        34'd6667162, 34'd39499041, 34'd35641750, 34'd6948301, 34'd258776
    };

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEAN = 2'd0,
        REG_STD  = 2'd1
    } t_reg_idx;

    // One result item.
    typedef struct packed {
        logic signed [OUT_W-1:0] sample;
        logic                    flag;
    } t_result;

endpackage

[hdl/ings_log2.sv]
// ----------------------------------------------------------------------------
// Tail fold and logarithm pipeline
// Folds the draw onto the lower tail, normalizes it, extracts the log2
// fraction by one squaring per stage and forms w = -2 ln v in Q30.
// ----------------------------------------------------------------------------
module ings_log2 import ings_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [UB-1:0]  i_code,
    output logic           o_valid,
    output logic           o_upper,
    output logic [W_W-1:0] o_w
);

    // Fold: a zero code counts as one, the upper half is mirrored.
    logic [UB-1:0] n_code;
    logic [UB-1:0] n_v;
    logic          r_f_valid;
    logic          r_f_upper;
    logic [UB-1:0] r_v;

    always_comb begin
        n_code = (i_code == '0) ? UB'(1) : i_code;
        n_v    = n_code[UB-1] ? (~n_code + UB'(1)) : n_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (i_en) begin
            r_f_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v       <= n_v;
            r_f_upper <= n_code[UB-1];
        end
    end

    // Normalize: exponent of the top set bit, mantissa moved to Q30.
    logic [E_W-1:0] n_e;
    logic [M_W-1:0] n_m;
    logic           r_n_valid;
    logic           r_n_upper;
    logic [E_W-1:0] r_n_e;
    logic [M_W-1:0] r_n_m;

    always_comb begin
        n_e = '0;
        for (int i = 0; i < UB; i++) begin
            if (r_v[i]) begin
                n_e = E_W'(i);
            end
        end
        n_m = M_W'({r_v, {MQ{1'b0}}} >> n_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (i_en) begin
            r_n_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n_upper <= r_f_upper;
            r_n_e     <= n_e;
            r_n_m     <= n_m;
        end
    end

    // Squaring stages: one fraction bit per stage.
    logic                r_sq_valid [SQ_STEPS];
    logic                r_sq_upper [SQ_STEPS];
    logic [E_W-1:0]      r_sq_e     [SQ_STEPS];
    logic [M_W-1:0]      r_sq_m     [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_sq_frac  [SQ_STEPS];

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        logic                p_valid;
        logic                p_upper;
        logic [E_W-1:0]      p_e;
        logic [M_W-1:0]      p_m;
        logic [SQ_STEPS-1:0] p_frac;
        logic [2*M_W-1:0]    prod;
        logic [M_W:0]        sq;
        logic                bit_one;

        if (g == 0) begin : g_first
            assign p_valid = r_n_valid;
            assign p_upper = r_n_upper;
            assign p_e     = r_n_e;
            assign p_m     = r_n_m;
            assign p_frac  = '0;
        end else begin : g_rest
            assign p_valid = r_sq_valid[g-1];
            assign p_upper = r_sq_upper[g-1];
            assign p_e     = r_sq_e[g-1];
            assign p_m     = r_sq_m[g-1];
            assign p_frac  = r_sq_frac[g-1];
        end

        assign prod    = p_m * p_m;
        assign sq      = prod[M_W+MQ:MQ];
        assign bit_one = sq[M_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_sq_valid[g] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_upper[g] <= p_upper;
                r_sq_e[g]     <= p_e;
                r_sq_m[g]     <= bit_one ? sq[M_W:1] : sq[M_W-1:0];
                r_sq_frac[g]  <= {p_frac[SQ_STEPS-2:0], bit_one};
            end
        end
    end

    // Scale by 2 ln 2: integer part and fraction products.
    localparam int LAST = SQ_STEPS - 1;
    localparam int FK_W = SQ_STEPS + K_W;

    logic [E_W:0]     n_ue;
    logic [FK_W-1:0]  n_fk;
    logic [W_W-1:0]   n_ek;
    logic             r_p_valid;
    logic             r_p_upper;
    logic [W_W-1:0]   r_p_ek;
    logic [K_W-1:0]   r_p_fk;

    always_comb begin
        n_ue = (E_W+1)'(UB) - {1'b0, r_sq_e[LAST]};
        n_fk = r_sq_frac[LAST] * TWO_LN2;
        n_ek = W_W'(n_ue) * W_W'(TWO_LN2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= r_sq_valid[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_upper <= r_sq_upper[LAST];
            r_p_ek    <= n_ek;
            r_p_fk    <= n_fk[FK_W-1:SQ_STEPS];
        end
    end

    // Difference gives w.
    logic           r_w_valid;
    logic           r_w_upper;
    logic [W_W-1:0] r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (i_en) begin
            r_w_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w_upper <= r_p_upper;
            r_w       <= r_p_ek - W_W'(r_p_fk);
        end
    end

    assign o_valid = r_w_valid;
    assign o_upper = r_w_upper;
    assign o_w     = r_w;

endmodule

[hdl/ings_sqrt.sv]
// ----------------------------------------------------------------------------
// Square root pipeline
// Digit-by-digit integer square root of w * 2^22, one result bit per stage,
// giving t in Q26.
// ----------------------------------------------------------------------------
module ings_sqrt import ings_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic           i_upper,
    input  logic [W_W-1:0] i_w,
    output logic           o_valid,
    output logic           o_upper,
    output logic [T_W-1:0] o_t
);

    localparam int CUR_W = SQRT_REM_W + 2;

    logic                  r_valid [T_W];
    logic                  r_upper [T_W];
    logic [X_W-1:0]        r_x     [T_W];
    logic [SQRT_REM_W-1:0] r_rem   [T_W];
    logic [T_W-1:0]        r_root  [T_W];

    for (genvar g = 0; g < T_W; g++) begin : g_step
        logic                  p_valid;
        logic                  p_upper;
        logic [X_W-1:0]        p_x;
        logic [SQRT_REM_W-1:0] p_rem;
        logic [T_W-1:0]        p_root;
        logic [CUR_W-1:0]      cur;
        logic [CUR_W-1:0]      trial;
        logic                  ge;

        if (g == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_upper = i_upper;
            assign p_x     = {i_w, {(X_W-W_W){1'b0}}};
            assign p_rem   = '0;
            assign p_root  = '0;
        end else begin : g_rest
            assign p_valid = r_valid[g-1];
            assign p_upper = r_upper[g-1];
            assign p_x     = r_x[g-1];
            assign p_rem   = r_rem[g-1];
            assign p_root  = r_root[g-1];
        end

        // Bring down two bits and try the next root bit.
        assign cur   = {p_rem, p_x[X_W-1 -: 2]};
        assign trial = CUR_W'({p_root, 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_upper[g] <= p_upper;
                r_x[g]     <= {p_x[X_W-3:0], 2'b00};
                r_rem[g]   <= ge ? SQRT_REM_W'(cur - trial) : SQRT_REM_W'(cur);
                r_root[g]  <= {p_root[T_W-2:0], ge};
            end
        end
    end

    assign o_valid = r_valid[T_W-1];
    assign o_upper = r_upper[T_W-1];
    assign o_t     = r_root[T_W-1];

endmodule

[hdl/ings_ratio.sv]
// ----------------------------------------------------------------------------
// Rational term pipeline
// Evaluates P(t) and Q(t) by Horner's rule, one coefficient per stage, then
// forms r = P * 2^26 / Q by restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ings_ratio import ings_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic           i_upper,
    input  logic [T_W-1:0] i_t,
    output logic           o_valid,
    output logic           o_upper,
    output logic [T_W-1:0] o_t,
    output logic [R_W-1:0] o_r
);

    localparam int HSTEPS = 4;
    localparam int PR_W   = ACC_W + T_W;
    localparam int NLOW   = R_W - FX;

    // Horner stages for both polynomials.
    logic             r_h_valid [HSTEPS];
    logic             r_h_upper [HSTEPS];
    logic [T_W-1:0]   r_h_t     [HSTEPS];
    logic [ACC_W-1:0] r_h_p     [HSTEPS];
    logic [ACC_W-1:0] r_h_q     [HSTEPS];

    for (genvar k = 0; k < HSTEPS; k++) begin : g_horner
        logic             p_valid;
        logic             p_upper;
        logic [T_W-1:0]   p_t;
        logic [ACC_W-1:0] p_p;
        logic [ACC_W-1:0] p_q;
        logic [PR_W-1:0]  prod_p;
        logic [PR_W-1:0]  prod_q;

        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_upper = i_upper;
            assign p_t     = i_t;
            assign p_p     = COEF_P[HSTEPS];
            assign p_q     = COEF_Q[HSTEPS];
        end else begin : g_rest
            assign p_valid = r_h_valid[k-1];
            assign p_upper = r_h_upper[k-1];
            assign p_t     = r_h_t[k-1];
            assign p_p     = r_h_p[k-1];
            assign p_q     = r_h_q[k-1];
        end

        assign prod_p = p_p * p_t;
        assign prod_q = p_q * p_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_h_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_h_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_h_upper[k] <= p_upper;
                r_h_t[k]     <= p_t;
                r_h_p[k]     <= COEF_P[HSTEPS-1-k] + prod_p[ACC_W+FX-1:FX];
                r_h_q[k]     <= COEF_Q[HSTEPS-1-k] + prod_q[ACC_W+FX-1:FX];
            end
        end
    end

    // Division stages: the quotient is known to fit in R_W bits.
    logic             r_d_valid [R_W];
    logic             r_d_upper [R_W];
    logic [T_W-1:0]   r_d_t     [R_W];
    logic [ACC_W-1:0] r_d_rem   [R_W];
    logic [R_W-1:0]   r_d_nb    [R_W];
    logic [ACC_W-1:0] r_d_q     [R_W];
    logic [R_W-1:0]   r_d_quo   [R_W];

    for (genvar j = 0; j < R_W; j++) begin : g_div
        logic             p_valid;
        logic             p_upper;
        logic [T_W-1:0]   p_t;
        logic [ACC_W-1:0] p_rem;
        logic [R_W-1:0]   p_nb;
        logic [ACC_W-1:0] p_q;
        logic [R_W-1:0]   p_quo;
        logic [ACC_W:0]   cur;
        logic             ge;

        if (j == 0) begin : g_first
            assign p_valid = r_h_valid[HSTEPS-1];
            assign p_upper = r_h_upper[HSTEPS-1];
            assign p_t     = r_h_t[HSTEPS-1];
            assign p_rem   = ACC_W'(r_h_p[HSTEPS-1][ACC_W-1:NLOW]);
            assign p_nb    = {r_h_p[HSTEPS-1][NLOW-1:0], {FX{1'b0}}};
            assign p_q     = r_h_q[HSTEPS-1];
            assign p_quo   = '0;
        end else begin : g_rest
            assign p_valid = r_d_valid[j-1];
            assign p_upper = r_d_upper[j-1];
            assign p_t     = r_d_t[j-1];
            assign p_rem   = r_d_rem[j-1];
            assign p_nb    = r_d_nb[j-1];
            assign p_q     = r_d_q[j-1];
            assign p_quo   = r_d_quo[j-1];
        end

        assign cur = {p_rem, p_nb[R_W-1]};
        assign ge  = (cur >= {1'b0, p_q});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_d_valid[j] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d_upper[j] <= p_upper;
                r_d_t[j]     <= p_t;
                r_d_rem[j]   <= ge ? ACC_W'(cur - {1'b0, p_q}) : ACC_W'(cur);
                r_d_nb[j]    <= {p_nb[R_W-2:0], 1'b0};
                r_d_q[j]     <= p_q;
                r_d_quo[j]   <= {p_quo[R_W-2:0], ge};
            end
        end
    end

    assign o_valid = r_d_valid[R_W-1];
    assign o_upper = r_d_upper[R_W-1];
    assign o_t     = r_d_t[R_W-1];
    assign o_r     = r_d_quo[R_W-1];

endmodule

[hdl/ings_scale.sv]
// ----------------------------------------------------------------------------
// Output scaling pipeline
// Forms z = +-(t - r), scales it by the std deviation, adds the mean, rounds
// back to Q16.16 and saturates.
// ----------------------------------------------------------------------------
module ings_scale import ings_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic                     i_upper,
    input  logic [T_W-1:0]           i_t,
    input  logic [R_W-1:0]           i_r,
    input  logic signed [MEAN_W-1:0] i_mean,
    input  logic [SD_W-1:0]          i_std,
    output logic                     o_valid,
    output t_result                  o_result
);

    localparam int PROD_W = SD_W + 1 + Z_W;
    localparam int SUM_W  = 64;
    localparam int Y_W    = SUM_W - FX;

    // Signed z in Q26.
    logic signed [Z_W-1:0] n_tz;
    logic signed [Z_W-1:0] n_rz;
    logic                  r_z_valid;
    logic signed [Z_W-1:0] r_z;

    assign n_tz = $signed({{(Z_W-T_W){1'b0}}, i_t});
    assign n_rz = $signed({{(Z_W-R_W){1'b0}}, i_r});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_valid <= 1'b0;
        end else if (i_en) begin
            r_z_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z <= i_upper ? (n_tz - n_rz) : (n_rz - n_tz);
        end
    end

    // Product with the std deviation.
    logic signed [PROD_W-1:0] n_prod;
    logic                     r_m_valid;
    logic signed [PROD_W-1:0] r_prod;

    assign n_prod = $signed({1'b0, i_std}) * r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= r_z_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    // Add the mean, round half up and clamp.
    logic [SUM_W-1:0] n_sum;
    logic [Y_W-1:0]   n_y;
    logic             n_pos_ovf;
    logic             n_neg_ovf;
    t_result          n_res;
    logic             r_o_valid;
    t_result          r_res;

    always_comb begin
        n_sum = {{(SUM_W-MEAN_W-FX){i_mean[MEAN_W-1]}}, i_mean, {FX{1'b0}}}
              + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod}
              + (SUM_W'(1) << (FX - 1));
        n_y       = n_sum[SUM_W-1:FX];
        n_pos_ovf = !n_y[Y_W-1] && (|n_y[Y_W-2:OUT_W-1]);
        n_neg_ovf = n_y[Y_W-1] && !(&n_y[Y_W-2:OUT_W-1]);
        n_res.flag = n_pos_ovf || n_neg_ovf;
        if (n_pos_ovf) begin
            n_res.sample = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (n_neg_ovf) begin
            n_res.sample = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            n_res.sample = $signed(n_y[OUT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_res;

endmodule

[hdl/ings_skid.sv]
// ----------------------------------------------------------------------------
// Output skid buffer
// Output register plus one spare entry, so the pipeline's advance enable is
// a registered signal and no transaction is lost when the sink stalls.
// ----------------------------------------------------------------------------
module ings_skid import ings_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    n_load;

    assign n_load  = i_ready || !r_out_valid;
    assign o_ready = !r_skid_valid;

    // Control: the spare entry fills only when the output is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (n_load) begin
            r_out_valid  <= r_skid_valid || i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[hdl/inverse_normal_gaussian_sample.sv]
// ----------------------------------------------------------------------------
// Gaussian sample generator, top level
// Throughput: one draw per cycle while the skid buffer's ready is high;
// the 30 squaring stages of the logarithm, the 29 root stages and the 30
// quotient stages are fully pipelined. Reset clears every valid bit, sets
// the mean to 0 and the std deviation to 1.0; the input is then ready.
// ----------------------------------------------------------------------------
module inverse_normal_gaussian_sample import ings_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [UB-1:0]           i_uniform_draw,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_gaussian_sample,
    output logic                    o_saturated_flag,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [UB-1:0]           i_cfg_data
);

    // Configuration registers.
    logic signed [MEAN_W-1:0] r_mean;
    logic [SD_W-1:0]          r_std;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
            r_std  <= SD_W'(65536);
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MEAN: r_mean <= $signed(i_cfg_data);
                REG_STD:  r_std  <= i_cfg_data[SD_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance follows the skid buffer's registered ready.
    logic           w_en;
    logic           w_l_valid, w_l_upper;
    logic [W_W-1:0] w_w;
    logic           w_s_valid, w_s_upper;
    logic [T_W-1:0] w_s_t;
    logic           w_r_valid, w_r_upper;
    logic [T_W-1:0] w_r_t;
    logic [R_W-1:0] w_r_r;
    logic           w_o_valid;
    t_result        w_result;
    t_result        w_out;

    assign o_in_ready = w_en;

    ings_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_code  (i_uniform_draw),
        .o_valid (w_l_valid),
        .o_upper (w_l_upper),
        .o_w     (w_w)
    );

    ings_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_l_valid),
        .i_upper (w_l_upper),
        .i_w     (w_w),
        .o_valid (w_s_valid),
        .o_upper (w_s_upper),
        .o_t     (w_s_t)
    );

    ings_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_upper (w_s_upper),
        .i_t     (w_s_t),
        .o_valid (w_r_valid),
        .o_upper (w_r_upper),
        .o_t     (w_r_t),
        .o_r     (w_r_r)
    );

    ings_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_r_valid),
        .i_upper  (w_r_upper),
        .i_t      (w_r_t),
        .i_r      (w_r_r),
        .i_mean   (r_mean),
        .i_std    (r_std),
        .o_valid  (w_o_valid),
        .o_result (w_result)
    );

    ings_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_o_valid),
        .i_data  (w_result),
        .o_ready (w_en),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .i_ready (i_out_ready)
    );

    assign o_gaussian_sample = w_out.sample;
    assign o_saturated_flag  = w_out.flag;

endmodule

[hdl/ings_checker.sv]
// ----------------------------------------------------------------------------
// Gaussian sample generator port checker
// Watches the top-level ports for output handling, saturation coding and
// input back-pressure behavior.
// ----------------------------------------------------------------------------
module ings_checker import ings_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [OUT_W-1:0] o_gaussian_sample,
    input logic                    o_saturated_flag
);

    // No result is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A held result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_gaussian_sample) && $stable(o_saturated_flag))
        else $error("held result changed");

    // A saturated result sits at one end of the range.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated_flag |->
            (o_gaussian_sample == 32'sh7fffffff) ||
            (o_gaussian_sample == -32'sh80000000))
        else $error("saturation flag without a clamped value");

    // Input ready drops only after the output was held.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready dropped without output stall");

endmodule

bind inverse_normal_gaussian_sample ings_checker u_ings_checker (.*);

[tb/sv/inverse_normal_gaussian_sample_checker.sv]
// ----------------------------------------------------------------------------
// Gaussian sample checker
// Watches the draw, result and register-write channels, predicts each sample
// with an integer model of the inverse normal datapath and compares results
// in order. Reports a running failure count to the testbench top.
// ----------------------------------------------------------------------------
module inverse_normal_gaussian_sample_checker import ings_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [UB-1:0]           i_uniform_draw,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [OUT_W-1:0] i_gaussian_sample,
    input  logic                    i_saturated_flag,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [UB-1:0]           i_cfg_data,
    output int                      o_errors,
    output int                      o_pending
);

    // Polynomial coefficients in Q26, rounded from the decimal constants.
    localparam longint unsigned NUM_P [5] = '{
        64'd21624652, 64'd67108864, 64'd22967478, 64'd1370572, 64'd3044
    };
    localparam longint unsigned DEN_Q [5] = '{
        64'd6667162, 64'd39499041, 64'd35641750, 64'd6948301, 64'd258776
    };
    localparam longint unsigned LN2X2 = 64'd1488522236;

    longint          mean_q16;
    longint unsigned sdev_q16;
    t_result         expected_samples[$];

    assign o_pending = expected_samples.size();

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned poly_q26(input longint unsigned c[5],
                                                 input longint unsigned t);
        longint unsigned acc;
        acc = c[4];
        for (int k = 3; k >= 0; k--) acc = c[k] + ((acc * t) >> 26);
        return acc;
    endfunction

    // Computes the saturated sample for one uniform draw.
    function automatic t_result gaussian_of(input logic [UB-1:0] draw);
        longint unsigned code, v, m, frac, w, t, p, q, r;
        longint          z, sum, y;
        longint unsigned biased;
        int              e;
        logic            upper;
        t_result         res;
        code = draw;
        if (code == 0) code = 1;
        upper = code >= (64'd1 << 31);
        v = upper ? (64'd1 << 32) - code : code;
        e = 0;
        while (e < 63 && (v >> (e + 1)) != 0) e++;
        m = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
        frac = 0;
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 30;
            frac <<= 1;
            if (m >= (64'd1 << 31)) begin
                frac |= 1;
                m >>= 1;
            end
        end
        w = longint'(32 - e) * LN2X2 - ((frac * LN2X2) >> 30);
        t = int_sqrt(w << 22);
        p = poly_q26(NUM_P, t);
        q = poly_q26(DEN_Q, t);
        r = (p << 26) / q;
        z = longint'(t) - longint'(r);
        if (!upper) z = -z;
        sum = mean_q16 * 64'sd67108864 + longint'(sdev_q16) * z;
        biased = longint'(sum) + (64'd1 << 62) + (64'd1 << 25);
        y = longint'(biased >> 26) - (64'sd1 <<< 36);
        res.flag = 1'b0;
        if (y > 64'sd2147483647) begin
            y = 64'sd2147483647;
            res.flag = 1'b1;
        end else if (y < -64'sd2147483648) begin
            y = -64'sd2147483648;
            res.flag = 1'b1;
        end
        res.sample = y[31:0];
        return res;
    endfunction

    // Track register writes, predict accepted draws and check results.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            mean_q16 <= 0;
            sdev_q16 <= 65536;
            o_errors <= 0;
            expected_samples.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_MEAN) mean_q16 <= longint'($signed(i_cfg_data));
                else if (i_cfg_index == REG_STD) sdev_q16 <= i_cfg_data[30:0];
            end
            if (i_in_valid && i_in_ready)
                expected_samples.insert(expected_samples.size(),
                                        gaussian_of(i_uniform_draw));
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected result %h flag %b", $time,
                             i_gaussian_sample, i_saturated_flag);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_samples.pop_front();
                    if (want.sample !== i_gaussian_sample || want.flag !== i_saturated_flag) begin
                        $display("%0t: sample expected %h flag %b, actual %h flag %b", $time,
                                 want.sample, want.flag, i_gaussian_sample, i_saturated_flag);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/inverse_normal_gaussian_sample_test.sv]
// ----------------------------------------------------------------------------
// Gaussian sample generator testbench
// Drives directed and random uniform draws through several mean and std
// deviation settings with bursty input and a stalling output, and lets the
// checker compare every sample against its prediction.
// ----------------------------------------------------------------------------
module inverse_normal_gaussian_sample_test;
    import ings_pkg::*;

    localparam int LATENCY      = 101;
    localparam int WDOG_MAX     = 20000;
    localparam int STALL_CYCLES = 400;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [UB-1:0]           draw = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [OUT_W-1:0] sample;
    logic                    sat_flag;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_MEAN;
    logic [UB-1:0]           cfg_data = '0;
    int                      errors;
    int                      pending;
    int                      idle_cycles = 0;
    logic                    long_stall = 1'b0;
    logic                    stall_go = 1'b0;
    logic                    done = 1'b0;

    always #2 i_clk = ~i_clk;

    inverse_normal_gaussian_sample i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_uniform_draw(draw),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_gaussian_sample(sample), .o_saturated_flag(sat_flag),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    inverse_normal_gaussian_sample_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_uniform_draw(draw),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_gaussian_sample(sample), .i_saturated_flag(sat_flag),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver stall pattern; a long hold-off overrides it.
    always @(posedge i_clk) begin
        if (long_stall) out_ready <= 1'b0;
        else if (done) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) != 0) || (($time / 800) % 3 == 0);
    end

    // Long receiver hold-off, timed here while the sender keeps offering.
    initial begin
        wait (stall_go);
        @(posedge i_clk);
        long_stall <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        long_stall <= 1'b0;
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("inverse_normal_gaussian_sample_test failed");
            $finish;
        end
    end

    task automatic send_draw(input logic [UB-1:0] code);
        draw     <= code;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Now and then drops valid after a draw and idles for a random gap.
    task automatic maybe_gap();
        int gap;
        if ($urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [UB-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random draw: full range, both tails, the midpoint region and shifted values.
    function automatic logic [UB-1:0] random_draw();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            2: return 32'h8000_0000 + $urandom_range(0, 512) - 256;
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [UB-1:0] directed [20];
        logic [UB-1:0] means [5];
        logic [UB-1:0] sdevs [5];
        directed = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000, 32'h4000_0000,
                     32'hC000_0000, 32'h1234_5678, 32'hEDCB_A987, 32'h0001_0000,
                     32'h7FFF_FFFE, 32'h0F0F_0F0F};
        means = '{32'h0001_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0};
        sdevs = '{32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0002_4000, 32'h0001_0000};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed draws at reset settings: tails, the midpoint and zero.
        foreach (directed[k]) send_draw(directed[k]);
        drain_results();

        // Register settings, extremes included; random draws, directed in phase 1.
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(REG_MEAN, means[phase]);
            write_reg(REG_STD, sdevs[phase]);
            if (phase == 1) foreach (directed[k]) send_draw(directed[k]);
            for (int n = 0; n < 180; n++) begin
                if (phase == 2 && n == 20) stall_go <= 1'b1;
                send_draw(random_draw());
                if (!(phase == 2 && n < 150)) maybe_gap();
            end
            drain_results();
        end

        done <= 1'b1;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && pending == 0) $display("inverse_normal_gaussian_sample_test passed");
        else $display("inverse_normal_gaussian_sample_test failed");
        $finish;
    end

endmodule
